// ===== hw/rtl/life_like_automaton_generation_defines.svh =====
// assertion macros for the life-like automaton generation block
`ifndef LIFE_LIKE_AUTOMATON_GENERATION_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_GENERATION_DEFINES_SVH

`ifndef SYNTH

`define LLA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lla assertion failed");

`define LLA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lla assertion failed");

`define LLA_ASSERT_DLY2(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##2 (cons)) \
        else $error("lla assertion failed");

`else

`define LLA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LLA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`define LLA_ASSERT_DLY2(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/lla_pkg.sv =====
// shared types and constants for the life-like automaton generation block
`default_nettype none

package lla_pkg;

    localparam int GRID_WIDTH  = 128;
    localparam int GRID_HEIGHT = 64;

    localparam int OP_W    = 2;
    localparam int NMASK_W = 9;
    localparam int RULE_W  = 10;
    localparam int CNT_W   = 4;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [NMASK_W-1:0] NMASK_RESET   = 9'd495;
    localparam logic [RULE_W-1:0]  SURVIVE_RESET = 10'd24;
    localparam logic [RULE_W-1:0]  BIRTH_RESET   = 10'd0;

    typedef enum logic [1:0] {
        REG_NEIGHBOUR = 2'd0,
        REG_SURVIVE   = 2'd1,
        REG_BIRTH     = 2'd2
    } t_reg;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_STEP
    } t_state;

    typedef struct packed {
        logic scan_clear;
        logic scan_init;
        logic step_run;
        logic cell_wr;
        logic cell_rd;
        logic out_load;
        logic out_zero;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic step_last;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/lla_ctrl.sv =====
// controller state machine: clearing pass, request decode, generation sequencing
`default_nettype none

module lla_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire [lla_pkg::OP_W-1:0]  i_operation,
    input  wire                      i_out_valid,
    input  wire                      i_out_stall,
    input  lla_pkg::t_status         i_status,
    output lla_pkg::t_cmd            o_cmd
);

    lla_pkg::t_state r_state;
    lla_pkg::t_state n_state;
    logic            out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lla_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        out_free   = !i_out_valid || !i_out_stall;
        case (r_state)
            lla_pkg::ST_CLEAR: begin
                o_cmd.scan_clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = lla_pkg::ST_IDLE;
                end
            end
            lla_pkg::ST_IDLE: begin
                o_in_stall = !out_free;
                if (i_in_valid && out_free) begin
                    case (lla_pkg::t_op'(i_operation))
                        lla_pkg::OP_WRITE: begin
                            o_cmd.cell_wr  = 1'b1;
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_zero = 1'b1;
                        end
                        lla_pkg::OP_READ: begin
                            o_cmd.cell_rd = 1'b1;
                            n_state       = lla_pkg::ST_READ;
                        end
                        lla_pkg::OP_STEP: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = lla_pkg::ST_STEP;
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_zero = 1'b1;
                        end
                    endcase
                end
            end
            lla_pkg::ST_READ: begin
                o_cmd.out_load = 1'b1;
                n_state        = lla_pkg::ST_IDLE;
            end
            lla_pkg::ST_STEP: begin
                o_cmd.step_run = 1'b1;
                if (i_status.step_last) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_zero = 1'b1;
                    n_state        = lla_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lla_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lla_dpath.sv =====
// datapath: cell plane memory, scan counters, 3x3 window line buffer and rule lookup
`default_nettype none

module lla_dpath #(
    parameter int GRID_WIDTH  = lla_pkg::GRID_WIDTH,
    parameter int GRID_HEIGHT = lla_pkg::GRID_HEIGHT
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  lla_pkg::t_cmd                  i_cmd,
    input  wire [$clog2(GRID_WIDTH)-1:0]   i_column,
    input  wire [$clog2(GRID_HEIGHT)-1:0]  i_row_index,
    input  wire                            i_write_state,
    input  wire [lla_pkg::NMASK_W-1:0]     i_neighbour_mask,
    input  wire [lla_pkg::RULE_W-1:0]      i_survive_mask,
    input  wire [lla_pkg::RULE_W-1:0]      i_birth_mask,
    output lla_pkg::t_status               o_status,
    output logic                           o_rd_bit
);

    localparam int CW      = $clog2(GRID_WIDTH);
    localparam int RW      = $clog2(GRID_HEIGHT);
    localparam int YW      = $clog2(GRID_HEIGHT + 3);
    localparam int LAG_MAX = GRID_WIDTH + 3;
    localparam int LW      = $clog2(GRID_WIDTH + 4);
    localparam int AW      = 1 + RW + CW;
    localparam int DEPTH   = 2 ** AW;
    localparam int TAPS    = 2 * GRID_WIDTH + 3;

    logic                     r_mem [0:DEPTH-1];
    logic                     r_rdata;
    logic                     r_rd_inside;
    logic                     r_plane;
    logic [CW-1:0]            r_rx;
    logic [YW-1:0]            r_ry;
    logic [CW-1:0]            r_cx;
    logic [RW-1:0]            r_cy;
    logic [LW-1:0]            r_lag;
    logic [TAPS-1:0]          r_sr;

    logic                     in_grid;
    logic                     scan_wrap;
    logic                     centre_vld;
    logic                     centre_last;
    logic                     left_ok;
    logic                     right_ok;
    logic                     up_ok;
    logic                     down_ok;
    logic [lla_pkg::NMASK_W-1:0] hit;
    logic [lla_pkg::CNT_W-1:0]   count;
    logic [lla_pkg::RULE_W-1:0]  rule;
    logic                     new_cell;
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic                     mem_wd;
    logic [AW-1:0]            mem_ra;

    assign in_grid = ({1'b0, i_column} < (CW+1)'(GRID_WIDTH))
                  && ({1'b0, i_row_index} < (RW+1)'(GRID_HEIGHT));

    assign scan_wrap   = (r_rx == CW'(GRID_WIDTH - 1));
    assign centre_vld  = i_cmd.step_run && (r_lag == LW'(LAG_MAX));
    assign centre_last = (r_cx == CW'(GRID_WIDTH - 1)) && (r_cy == RW'(GRID_HEIGHT - 1));

    assign o_status.clear_last = scan_wrap && (r_ry == YW'(GRID_HEIGHT - 1));
    assign o_status.step_last  = (r_lag == LW'(LAG_MAX)) && centre_last;
    assign o_rd_bit            = r_rdata && r_rd_inside;

    // window taps: r_sr[0] is the cell one row below and one column right of the centre
    assign left_ok  = (r_cx != '0);
    assign right_ok = (r_cx != CW'(GRID_WIDTH - 1));
    assign up_ok    = (r_cy != '0);
    assign down_ok  = (r_cy != RW'(GRID_HEIGHT - 1));

    always_comb begin
        hit[8] = i_neighbour_mask[8] && right_ok && down_ok && r_sr[0];
        hit[5] = i_neighbour_mask[5] && down_ok && r_sr[1];
        hit[2] = i_neighbour_mask[2] && left_ok && down_ok && r_sr[2];
        hit[7] = i_neighbour_mask[7] && right_ok && r_sr[GRID_WIDTH];
        hit[4] = i_neighbour_mask[4] && r_sr[GRID_WIDTH+1];
        hit[1] = i_neighbour_mask[1] && left_ok && r_sr[GRID_WIDTH+2];
        hit[6] = i_neighbour_mask[6] && right_ok && up_ok && r_sr[2*GRID_WIDTH];
        hit[3] = i_neighbour_mask[3] && up_ok && r_sr[2*GRID_WIDTH+1];
        hit[0] = i_neighbour_mask[0] && left_ok && up_ok && r_sr[2*GRID_WIDTH+2];
        count  = {3'b000, hit[0]} + {3'b000, hit[1]} + {3'b000, hit[2]}
               + {3'b000, hit[3]} + {3'b000, hit[4]} + {3'b000, hit[5]}
               + {3'b000, hit[6]} + {3'b000, hit[7]} + {3'b000, hit[8]};
        rule     = r_sr[GRID_WIDTH+1] ? i_survive_mask : i_birth_mask;
        new_cell = rule[count];
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = {1'b0, r_ry[RW-1:0], r_rx};
        mem_wd = 1'b0;
        if (i_cmd.scan_clear) begin
            mem_we = 1'b1;
        end else if (centre_vld) begin
            mem_we = 1'b1;
            mem_wa = {!r_plane, r_cy, r_cx};
            mem_wd = new_cell;
        end else if (i_cmd.cell_wr && in_grid) begin
            mem_we = 1'b1;
            mem_wa = {r_plane, i_row_index, i_column};
            mem_wd = i_write_state;
        end
        if (i_cmd.cell_rd) begin
            mem_ra = {r_plane, i_row_index, i_column};
        end else begin
            mem_ra = {r_plane, r_ry[RW-1:0], r_rx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_rd) begin
            r_rd_inside <= in_grid;
        end
        if (i_cmd.step_run) begin
            r_sr <= {r_sr[TAPS-2:0], r_rdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= 1'b0;
            r_rx    <= '0;
            r_ry    <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_lag   <= '0;
        end else if (i_cmd.scan_init) begin
            r_rx  <= '0;
            r_ry  <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_lag <= '0;
        end else if (i_cmd.scan_clear || i_cmd.step_run) begin
            if (scan_wrap) begin
                r_rx <= '0;
                r_ry <= r_ry + YW'(1);
            end else begin
                r_rx <= r_rx + CW'(1);
            end
            if (i_cmd.step_run && !centre_vld) begin
                r_lag <= r_lag + LW'(1);
            end
            if (centre_vld) begin
                if (r_cx == CW'(GRID_WIDTH - 1)) begin
                    r_cx <= '0;
                    r_cy <= r_cy + RW'(1);
                end else begin
                    r_cx <= r_cx + CW'(1);
                end
                if (centre_last) begin
                    r_plane <= !r_plane;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/life_like_automaton_generation.sv =====
// top level of the life-like automaton generation block: config registers, result register
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_operation i_column i_row_index i_write_state
//  result    out        o_out_valid / i_out_stall o_cell_state
//  config    in         psel penable pwrite pready paddr pwdata prdata
//
//  write and unused codes: result valid in the cycle after the request is taken
//  read: one read of the cell memory into r_rdata, then the result register is loaded
//  step: one cell a cycle through the memory read port plus the window line buffer fill
//  after reset a clearing pass over the grid holds requests stalled
//  a request is taken when the result register is empty or being emptied
`default_nettype none

module life_like_automaton_generation #(
    parameter int GRID_WIDTH  = lla_pkg::GRID_WIDTH,
    parameter int GRID_HEIGHT = lla_pkg::GRID_HEIGHT
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire [lla_pkg::OP_W-1:0]        i_operation,
    input  wire [$clog2(GRID_WIDTH)-1:0]   i_column,
    input  wire [$clog2(GRID_HEIGHT)-1:0]  i_row_index,
    input  wire                            i_write_state,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_cell_state,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [lla_pkg::APB_AW-1:0]      paddr,
    input  wire [lla_pkg::APB_DW-1:0]      pwdata,
    output logic [lla_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    logic [lla_pkg::NMASK_W-1:0] r_nmask;
    logic [lla_pkg::RULE_W-1:0]  r_survive;
    logic [lla_pkg::RULE_W-1:0]  r_birth;
    logic                        r_out_valid;
    logic                        r_cell_state;

    lla_pkg::t_cmd    cmd;
    lla_pkg::t_status status;
    logic             rd_bit;
    logic             cfg_wr;
    logic             in_accept;

    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite && pready;
    assign o_out_valid  = r_out_valid;
    assign o_cell_state = r_cell_state;
    assign in_accept    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nmask   <= lla_pkg::NMASK_RESET;
            r_survive <= lla_pkg::SURVIVE_RESET;
            r_birth   <= lla_pkg::BIRTH_RESET;
        end else if (cfg_wr) begin
            case (lla_pkg::t_reg'(paddr[3:2]))
                lla_pkg::REG_NEIGHBOUR: r_nmask   <= pwdata[lla_pkg::NMASK_W-1:0];
                lla_pkg::REG_SURVIVE:   r_survive <= pwdata[lla_pkg::RULE_W-1:0];
                lla_pkg::REG_BIRTH:     r_birth   <= pwdata[lla_pkg::RULE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (lla_pkg::t_reg'(paddr[3:2]))
            lla_pkg::REG_NEIGHBOUR: prdata = lla_pkg::APB_DW'(r_nmask);
            lla_pkg::REG_SURVIVE:   prdata = lla_pkg::APB_DW'(r_survive);
            lla_pkg::REG_BIRTH:     prdata = lla_pkg::APB_DW'(r_birth);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_cell_state <= cmd.out_zero ? 1'b0 : rd_bit;
        end
    end

    lla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_out_valid (r_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lla_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_column         (i_column),
        .i_row_index      (i_row_index),
        .i_write_state    (i_write_state),
        .i_neighbour_mask (r_nmask),
        .i_survive_mask   (r_survive),
        .i_birth_mask     (r_birth),
        .o_status         (status),
        .o_rd_bit         (rd_bit)
    );

`include "life_like_automaton_generation_defines.svh"

    // a result is never loaded over one still held by the receiver
    `LLA_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, cmd.out_load && r_out_valid, !i_out_stall)

    // read and step requests keep the request side stalled in the following cycle
    `LLA_ASSERT_NXT(a_busy_after_long, i_clk, i_rst_n, in_accept && (i_operation == lla_pkg::OP_READ || i_operation == lla_pkg::OP_STEP), o_in_stall)

    // a read result shows up after the cell memory read and the result register load that follow the request
    `LLA_ASSERT_DLY2(a_read_latency, i_clk, i_rst_n, in_accept && i_operation == lla_pkg::OP_READ, o_out_valid)

endmodule

`default_nettype wire
